[rtl/rbt_pkg.sv]
// Shared types and constants for the range block table.
package rbt_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERLAP  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [23:0] group_id;
        logic [23:0] first_index;
        logic [15:0] block_count;
        logic [15:0] tag;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  hit_slot;
        logic [23:0] hit_first;
        logic [15:0] hit_count;
        logic [15:0] hit_tag;
    } out_item_t;

    typedef struct packed {
        logic [23:0] group_id;
        logic [23:0] first_index;
        logic [15:0] block_count;
        logic [15:0] tag;
    } entry_t;

    // Outcome of comparing one stored entry against the request.
    typedef struct packed {
        logic grp_eq;
        logic clash;
        logic holds;
        logic exact;
    } cmp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

endpackage

[rtl/range_block_table_top.sv]
// Top level of the range block table: sequencer, entry memory and result register.
//
//  Channel | Ports                    | Direction | Payload
//  --------+--------------------------+-----------+-----------
//  input   | s_valid, s_ready, s_data | in        | in_item_t
//  result  | m_valid, m_ready, m_data | out       | out_item_t
//
// Each transaction runs through the sequencer states in order: accept in
// S_IDLE, S_SCAN in which the single comparison unit walks the entry memory
// one read a cycle, S_DRAIN to compare the last entry, and S_DONE to commit
// the table update and load the result register.
// Reset clears the valid marks, the sequencer and the result valid flag;
// the entry memory itself is not cleared, since invalid entries are never used.
// A stalled result holds the sequencer in its commit step, but an input
// transaction is still taken while an earlier result waits on m_ready.
module range_block_table_top
    import rbt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Entry storage and its valid marks.
    entry_t                mem [ENTRIES];
    logic [ENTRIES-1:0]    valid_reg;
    logic [ENTRIES-1:0]    valid_next;

    // Sequencer.
    state_t                state_reg;
    state_t                state_next;
    logic [IDX_W-1:0]      scan_idx_reg;
    logic [IDX_W-1:0]      scan_idx_next;
    logic                  rd_pending_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    entry_t                rd_entry_reg;
    logic                  rd_vld_reg;

    // The request being worked on.
    in_item_t              req_reg;

    // Scan accumulators.
    logic                  clash_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      found_slot_reg;
    entry_t                found_entry_reg;
    logic                  free_found_reg;
    logic [IDX_W-1:0]      free_slot_reg;

    // Result register.
    logic                  m_valid_reg;
    out_item_t             m_data_reg;

    cmp_t                  cmp;
    logic                  accept;
    logic                  out_free;
    logic                  commit;
    logic                  commit_add;
    logic                  commit_remove;
    out_item_t             result;
    logic [31:0]           slot_wide;
    logic [IDX_W-1:0]      result_slot;

    rbt_cmp u_cmp (
        .entry  (rd_entry_reg),
        .req    (req_reg),
        .result (cmp)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = (state_reg == S_DONE) && out_free;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Result assembly from what the scan gathered.
    always_comb begin
        result        = '0;
        result.status = ST_NOTFOUND;
        result_slot   = '0;
        commit_add    = 1'b0;
        commit_remove = 1'b0;
        case (req_reg.opcode)
            OP_ADD: begin
                if (clash_reg) begin
                    result.status = ST_OVERLAP;
                end else if (!free_found_reg) begin
                    result.status = ST_FULL;
                end else begin
                    result.status = ST_OK;
                    result_slot   = free_slot_reg;
                    commit_add    = commit;
                end
            end
            OP_REMOVE: begin
                if (found_reg) begin
                    result.status = ST_OK;
                    result_slot   = found_slot_reg;
                    commit_remove = commit;
                end
            end
            OP_FIND: begin
                if (found_reg) begin
                    result.status    = ST_OK;
                    result_slot      = found_slot_reg;
                    result.hit_first = found_entry_reg.first_index;
                    result.hit_count = found_entry_reg.block_count;
                    result.hit_tag   = found_entry_reg.tag;
                end
            end
            default: begin
                result.status = ST_NOTFOUND;
            end
        endcase
        slot_wide       = 32'(result_slot);
        result.hit_slot = slot_wide[3:0];
    end

    // Next state of the sequencer and of the valid marks.
    always_comb begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        valid_next    = valid_reg;
        case (state_reg)
            S_IDLE: begin
                scan_idx_next = '0;
                if (accept) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_idx_reg == LAST_IDX) begin
                    state_next = S_DRAIN;
                end else begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (commit_add) begin
            valid_next[free_slot_reg] = 1'b1;
        end
        if (commit_remove) begin
            valid_next[found_slot_reg] = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            scan_idx_reg   <= '0;
            rd_pending_reg <= 1'b0;
            valid_reg      <= '0;
            m_valid_reg    <= 1'b0;
            clash_reg      <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            scan_idx_reg   <= scan_idx_next;
            rd_pending_reg <= (state_reg == S_SCAN);
            valid_reg      <= valid_next;
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                clash_reg      <= 1'b0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end else if (rd_pending_reg) begin
                if (rd_vld_reg) begin
                    if ((req_reg.opcode == OP_ADD) && cmp.clash) begin
                        clash_reg <= 1'b1;
                    end
                    if (!found_reg &&
                        (((req_reg.opcode == OP_REMOVE) && cmp.exact) ||
                         ((req_reg.opcode == OP_FIND) && cmp.holds))) begin
                        found_reg <= 1'b1;
                    end
                end else if (!free_found_reg) begin
                    free_found_reg <= 1'b1;
                end
            end
        end
    end

    // Payload registers: request, memory read stage and captured hits.
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_data;
        end
        if (state_reg == S_SCAN) begin
            rd_entry_reg <= mem[scan_idx_reg];
            rd_vld_reg   <= valid_reg[scan_idx_reg];
            rd_idx_reg   <= scan_idx_reg;
        end
        if (rd_pending_reg) begin
            if (rd_vld_reg) begin
                if (!found_reg &&
                    (((req_reg.opcode == OP_REMOVE) && cmp.exact) ||
                     ((req_reg.opcode == OP_FIND) && cmp.holds))) begin
                    found_slot_reg  <= rd_idx_reg;
                    found_entry_reg <= rd_entry_reg;
                end
            end else if (!free_found_reg) begin
                free_slot_reg <= rd_idx_reg;
            end
        end
        if (commit) begin
            m_data_reg <= result;
        end
    end

    // Entry memory write port.
    always_ff @(posedge aclk) begin
        if (commit_add) begin
            mem[free_slot_reg] <= '{group_id:    req_reg.group_id,
                                    first_index: req_reg.first_index,
                                    block_count: req_reg.block_count,
                                    tag:         req_reg.tag};
        end
    end

    // A result is loaded only from the commit step of the sequencer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result appeared outside the commit step");

    // A table-full answer is given only when every entry is in use.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && (req_reg.opcode == OP_ADD) && (result.status == ST_FULL))
            |-> (&valid_reg))
        else $error("table full reported with a free entry");

    // A successful add marks exactly one more entry as in use.
    assert property (@(posedge aclk) disable iff (!aresetn)
        commit_add |=> ($countones(valid_reg) == $past($countones(valid_reg)) + 1))
        else $error("add did not claim exactly one entry");

    // A successful remove frees exactly one entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        commit_remove |=> ($countones(valid_reg) + 1 == $past($countones(valid_reg))))
        else $error("remove did not free exactly one entry");

endmodule

[rtl/rbt_cmp.sv]
// Range comparison unit shared by every step of the table scan.
module rbt_cmp
    import rbt_pkg::*;
(
    input  entry_t   entry,
    input  in_item_t req,
    output cmp_t     result
);

    logic [24:0] stored_end;
    logic [24:0] req_end;
    logic        req_in_stored;
    logic        stored_in_req;

    assign stored_end = {1'b0, entry.first_index} + {9'd0, entry.block_count};
    assign req_end    = {1'b0, req.first_index} + {9'd0, req.block_count};

    // The request index lies inside the stored range; find uses this alone.
    assign req_in_stored = (req.first_index >= entry.first_index) &&
                           ({1'b0, req.first_index} < stored_end);
    assign stored_in_req = (entry.first_index >= req.first_index) &&
                           ({1'b0, entry.first_index} < req_end);

    assign result.grp_eq = (entry.group_id == req.group_id);
    assign result.holds  = result.grp_eq && req_in_stored;
    assign result.clash  = result.grp_eq && (req_in_stored || stored_in_req);
    assign result.exact  = result.grp_eq &&
                           (entry.first_index == req.first_index) &&
                           (entry.block_count == req.block_count);

endmodule

[tb/testbench.sv]
// Self-checking testbench for the range block table: shadow table, stimulus and checks.
`timescale 1ns / 1ps

module testbench
    import rbt_pkg::*;
();

    // Shadow copy of the range table. It applies each accepted request to its own
    // entries, queues the response the block must give, and checks responses in order.
    class range_table_shadow;
        bit        slot_used[ENTRIES];
        entry_t    slot_entry[ENTRIES];
        out_item_t pending[$];
        int        failures;

        function void apply_request(in_item_t req);
            out_item_t want;
            int        free_slot;
            bit        clash;
            logic [24:0] req_end;
            logic [24:0] ent_end;
            want = '0;
            want.status = ST_NOTFOUND;
            free_slot = -1;
            clash = 1'b0;
            req_end = {1'b0, req.first_index} + {9'd0, req.block_count};
            case (req.opcode)
                OP_ADD: begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (slot_used[i]) begin
                            ent_end = {1'b0, slot_entry[i].first_index} +
                                      {9'd0, slot_entry[i].block_count};
                            if (slot_entry[i].group_id == req.group_id &&
                                ((slot_entry[i].first_index >= req.first_index &&
                                  slot_entry[i].first_index < req_end) ||
                                 (req.first_index >= slot_entry[i].first_index &&
                                  req.first_index < ent_end)))
                                clash = 1'b1;
                        end else if (free_slot < 0) begin
                            free_slot = i;
                        end
                    end
                    if (clash) begin
                        want.status = ST_OVERLAP;
                    end else if (free_slot < 0) begin
                        want.status = ST_FULL;
                    end else begin
                        slot_used[free_slot] = 1'b1;
                        slot_entry[free_slot] = '{req.group_id, req.first_index,
                                                  req.block_count, req.tag};
                        want.status = ST_OK;
                        want.hit_slot = free_slot[3:0];
                    end
                end
                OP_REMOVE: begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (slot_used[i] && slot_entry[i].group_id == req.group_id &&
                            slot_entry[i].first_index == req.first_index &&
                            slot_entry[i].block_count == req.block_count) begin
                            slot_used[i] = 1'b0;
                            want.status = ST_OK;
                            want.hit_slot = i[3:0];
                            break;
                        end
                    end
                end
                OP_FIND: begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        ent_end = {1'b0, slot_entry[i].first_index} +
                                  {9'd0, slot_entry[i].block_count};
                        if (slot_used[i] && slot_entry[i].group_id == req.group_id &&
                            slot_entry[i].first_index <= req.first_index &&
                            ent_end > {1'b0, req.first_index}) begin
                            want.status = ST_OK;
                            want.hit_slot = i[3:0];
                            want.hit_first = slot_entry[i].first_index;
                            want.hit_count = slot_entry[i].block_count;
                            want.hit_tag = slot_entry[i].tag;
                            break;
                        end
                    end
                end
                default: begin
                end
            endcase
            pending.push_back(want);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                failures++;
            end
        endfunction

        function void check_response(out_item_t got);
            out_item_t want;
            if (pending.size() == 0) begin
                $error("response with nothing outstanding: status %0d slot %0d",
                       got.status, got.hit_slot);
                failures++;
                return;
            end
            want = pending.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("hit_slot", 32'(want.hit_slot), 32'(got.hit_slot));
            compare_field("hit_first", 32'(want.hit_first), 32'(got.hit_first));
            compare_field("hit_count", 32'(want.hit_count), 32'(got.hit_count));
            compare_field("hit_tag", 32'(want.hit_tag), 32'(got.hit_tag));
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        function int live_count();
            int n;
            n = 0;
            for (int i = 0; i < ENTRIES; i++)
                if (slot_used[i])
                    n++;
            return n;
        endfunction

        function int random_slot();
            int live[$];
            for (int i = 0; i < ENTRIES; i++)
                if (slot_used[i])
                    live.push_back(i);
            if (live.size() == 0)
                return -1;
            return live[$urandom_range(0, live.size() - 1)];
        endfunction
    endclass

    // Opcode 3 has no name in the package; the block must treat it as a no-op.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_REQUESTS = 650;
    localparam int DRAIN_EVERY     = 200;
    // Receiver hold-off long enough for the block to fill and stall its input.
    localparam int LONG_HOLD       = 400;
    localparam int LONG_HOLD_AFTER = 300;
    // Cycles to linger after the last response.
    localparam int TAIL_CYCLES     = 60;

    typedef enum {
        READY_ALWAYS,
        READY_COIN,
        READY_PATTERN
    } ready_mode_e;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    range_table_shadow shadow = new();

    // Requests in the current burst before the sender idles again.
    int burst_left = 0;

    range_block_table_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Watchdog. The slowest correct run ends well before the timeout, so it
    // only trips on a hang.
    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic in_item_t req_of(logic [1:0] op, logic [23:0] grp,
                                        logic [23:0] first, logic [15:0] cnt,
                                        logic [15:0] tg);
        in_item_t req;
        req.opcode = op;
        req.group_id = grp;
        req.first_index = first;
        req.block_count = cnt;
        req.tag = tg;
        return req;
    endfunction

    // Groups come mostly from a small pool so that ranges actually meet; group
    // zero and the all-ones group are in the pool, plus some fully random ids.
    function automatic logic [23:0] pick_group();
        case ($urandom_range(0, 9))
            0: return 24'd0;
            7: return 24'hFFFFFF;
            8, 9: return 24'($urandom);
            default: return 24'($urandom_range(1, 3));
        endcase
    endfunction

    // Indices cluster in a few windows, one at the very top of the index space
    // so that first + count runs past 24 bits.
    function automatic logic [23:0] pick_index();
        case ($urandom_range(0, 9))
            0, 1: return 24'($urandom);
            2, 3: return 24'(24'hFFFF00 + $urandom_range(0, 255));
            4: return 24'($urandom_range(0, 63));
            default: return 24'(24'h001000 + $urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] pick_count();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(1, 24));
        endcase
    endfunction

    // Builds the next request from the current contents of the shadow table.
    // While filling, adds dominate until the table is full; while emptying,
    // removes of stored ranges dominate. Removes and finds mostly target a
    // stored range, with off-by-one variants to probe the edges.
    function automatic in_item_t make_request(bit filling);
        in_item_t req;
        entry_t   ent;
        int       roll;
        int       pick;
        req = req_of(OP_ADD, pick_group(), pick_index(), pick_count(), 16'($urandom));
        ent = '0;
        roll = $urandom_range(0, 99);
        pick = shadow.random_slot();
        if (pick >= 0)
            ent = shadow.slot_entry[pick];
        if (roll < 6) begin
            req.opcode = 2'($urandom_range(0, 3));
            req.group_id = 24'($urandom);
            req.first_index = 24'($urandom);
            req.block_count = 16'($urandom);
        end else if (roll < 8) begin
            req.opcode = OP_UNUSED;
        end else if (roll < (filling ? 62 : 25)) begin
            req.opcode = OP_ADD;
            if (pick >= 0 && $urandom_range(0, 2) == 0) begin
                req.group_id = ent.group_id;
                req.first_index = 24'(ent.first_index + $urandom_range(0, 8) - 4);
            end
        end else if (roll < (filling ? 77 : 70)) begin
            req.opcode = OP_REMOVE;
            if (pick >= 0) begin
                req.group_id = ent.group_id;
                req.first_index = ent.first_index;
                req.block_count = ent.block_count;
                case ($urandom_range(0, 9))
                    0: req.block_count = 16'(ent.block_count + 1);
                    1: req.first_index = 24'(ent.first_index - 1);
                    2: req.group_id = ent.group_id ^ 24'd1;
                    default: begin
                    end
                endcase
            end
        end else begin
            req.opcode = OP_FIND;
            if (pick >= 0) begin
                req.group_id = ent.group_id;
                req.first_index = ent.first_index;
                case ($urandom_range(0, 7))
                    0: req.first_index = 24'(ent.first_index - 1);
                    1: req.first_index = 24'(ent.first_index + ent.block_count);
                    default: begin
                        if (ent.block_count != 0)
                            req.first_index = 24'(ent.first_index +
                                              $urandom_range(0, ent.block_count - 1));
                    end
                endcase
            end
        end
        return req;
    endfunction

    // Offers one request and returns at the edge where it is accepted. The
    // sender works in bursts; between bursts it drops valid for a random gap.
    // A zero gap keeps valid high, and now and then a long burst runs with
    // no idling at all. Valid is never lowered once raised until acceptance.
    task automatic offer(in_item_t req);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 10);
            gap = $urandom_range(0, 20);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data <= req;
        do
            @(posedge aclk);
        while (!s_ready);
        shadow.apply_request(req);
    endtask

    // Stops offering and waits until every queued response has been checked.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        burst_left = 0;
        while (shadow.outstanding() != 0)
            @(posedge aclk);
    endtask

    // Sender: reset, the directed list, then the random run.
    initial begin
        int  sent;
        bit  filling;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // An empty table answers not found to everything.
        offer(req_of(OP_FIND,   24'd1, 24'd0,   16'd1,  16'h0000));
        offer(req_of(OP_REMOVE, 24'd1, 24'd0,   16'd1,  16'h0000));
        // One range of group 1 covering 100..109; probe both ends and just outside.
        offer(req_of(OP_ADD,    24'd1, 24'd100, 16'd10, 16'hAAAA));
        offer(req_of(OP_FIND,   24'd1, 24'd100, 16'd0,  16'h0000));
        offer(req_of(OP_FIND,   24'd1, 24'd109, 16'd0,  16'h0000));
        offer(req_of(OP_FIND,   24'd1, 24'd110, 16'd0,  16'h0000));
        offer(req_of(OP_FIND,   24'd1, 24'd99,  16'd0,  16'h0000));
        // A range ending right where the first begins is fine; one more index clashes.
        offer(req_of(OP_ADD,    24'd1, 24'd95,  16'd5,  16'h5555));
        offer(req_of(OP_ADD,    24'd1, 24'd95,  16'd6,  16'h1234));
        // New range starting inside a stored one clashes the other way round.
        offer(req_of(OP_ADD,    24'd1, 24'd105, 16'd1,  16'h4321));
        // Same span in another group never clashes; group zero is an ordinary group.
        offer(req_of(OP_ADD,    24'd2, 24'd100, 16'd10, 16'hBEEF));
        offer(req_of(OP_ADD,    24'd0, 24'd0,   16'd1,  16'h0001));
        // A zero-length range is stored, never found, but still blocks an add
        // that covers its start.
        offer(req_of(OP_ADD,    24'd1, 24'd200, 16'd0,  16'h0F0F));
        offer(req_of(OP_FIND,   24'd1, 24'd200, 16'd0,  16'h0000));
        offer(req_of(OP_ADD,    24'd1, 24'd200, 16'd1,  16'hF0F0));
        // All-ones everywhere: the end of the range lies past 24 bits and must not wrap.
        offer(req_of(OP_ADD,    24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF));
        offer(req_of(OP_FIND,   24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF));
        offer(req_of(OP_ADD,    24'hFFFFFF, 24'd0,      16'hFFFF, 16'h8001));
        // Remove needs an exact match of group, first and count.
        offer(req_of(OP_REMOVE, 24'd1, 24'd100, 16'd9,  16'h0000));
        offer(req_of(OP_REMOVE, 24'd1, 24'd100, 16'd10, 16'h0000));
        offer(req_of(OP_REMOVE, 24'd1, 24'd200, 16'd0,  16'h0000));
        // The unused opcode leaves the table alone and answers not found.
        offer(req_of(OP_UNUSED, 24'd2, 24'd100, 16'd10, 16'h7777));
        // The freed slot zero is the lowest free slot again.
        offer(req_of(OP_ADD,    24'd1, 24'd50,  16'd1,  16'h3C3C));
        offer(req_of(OP_FIND,   24'd2, 24'd109, 16'd0,  16'h0000));
        wait_for_drain();

        // Random run. The table swings between filling up, where adds meet a
        // full table and overlaps must win over the full status, and emptying.
        filling = 1'b1;
        for (sent = 0; sent < RANDOM_REQUESTS; sent++) begin
            if (shadow.live_count() == 0)
                filling = 1'b1;
            else if (shadow.live_count() == ENTRIES && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            if (sent % DRAIN_EVERY == DRAIN_EVERY - 1)
                wait_for_drain();
            offer(make_request(filling));
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (shadow.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Receiver: checks each response transaction and drives m_ready. It runs
    // in phases of random length, each either always ready, ready on a coin
    // toss, or following a rotating bit pattern. Once, after a fixed number
    // of responses, it holds m_ready low for a long stretch so that the
    // block backs up and stalls its input while the sender keeps offering.
    initial begin
        int          responses_seen;
        int          hold_left;
        int          phase_left;
        ready_mode_e ready_mode;
        logic [31:0] ready_bits;
        responses_seen = 0;
        hold_left = 0;
        phase_left = 0;
        ready_mode = READY_ALWAYS;
        ready_bits = '1;
        while (!aresetn)
            @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                shadow.check_response(m_data);
                responses_seen++;
                if (responses_seen == LONG_HOLD_AFTER)
                    hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (phase_left == 0) begin
                    ready_mode = ready_mode_e'($urandom_range(0, 2));
                    ready_bits = $urandom;
                    phase_left = $urandom_range(20, 120);
                end
                phase_left--;
                case (ready_mode)
                    READY_ALWAYS: m_ready <= 1'b1;
                    READY_COIN: m_ready <= 1'($urandom_range(0, 1));
                    default: begin
                        m_ready <= ready_bits[0];
                        ready_bits = {ready_bits[0], ready_bits[31:1]};
                    end
                endcase
            end
        end
    end

endmodule
